### rtl/ncdf_pkg.sv
// shared constants and types for the normal cdf z-score unit
`timescale 1ns / 1ps
package ncdf_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WEEKS = 2'd1,
    ST_VOL   = 2'd2
  } status_t;

  // iteration counts
  localparam int SQRT_STEPS   = 24;
  localparam int TAYLOR_TERMS = 14;
  localparam int EXP_STEPS    = 24;
  localparam int RECIP_SHIFT  = 35;

  // fixed-point constants
  localparam logic [31:0] COEF_R  = 32'd3037000500;  // 1/sqrt2, q.32
  localparam logic [30:0] COEF_P  = 31'd1406993061;  // p, q0.32
  localparam logic [30:0] COEF_E1 = 31'd1580030169;  // e^-1, q0.32
  localparam logic [30:0] X_LIMIT = 31'd83886080;    // 5.0 in q8.24

  // erf polynomial coefficients a1..a5, q.30
  localparam logic signed [33:0] POLY_COEF [5] = '{
    34'sd273621191, -34'sd305476044, 34'sd1526231383,
    -34'sd1560310108, 34'sd1139675401
  };

endpackage

### rtl/ncdf_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module ncdf_div #(
  parameter int DEN_W  = 32,
  parameter int QUO_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  in_rem,
  input  logic [QUO_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic [DEN_W-1:0]  rem_r  [QUO_W];
  logic [QUO_W-1:0]  sh_r   [QUO_W];
  logic [DEN_W-1:0]  den_r  [QUO_W];
  logic [SIDE_W-1:0] side_r [QUO_W];
  logic [QUO_W-1:0]  vld_r;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QUO_W-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_st
    logic [DEN_W-1:0]  rem_in;
    logic [QUO_W-1:0]  sh_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in  = in_rem;
      assign sh_in   = in_num;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign sh_in   = sh_r[i-1];
      assign den_in  = den_r[i-1];
      assign side_in = side_r[i-1];
    end

    // shift in the next dividend bit and try to subtract
    assign trial = {rem_in, sh_in[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
        sh_r[i]   <= {sh_in[QUO_W-2:0], ge};
        den_r[i]  <= den_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_quo   = sh_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];

endmodule

### rtl/normal_cdf_zscore_probability_unit.sv
// top level: z = sqrt(weeks)*mu/sigma and its normal cdf, fully pipelined
// throughput: one item per cycle while the skid entry is empty; the long
// stretches are the 64-stage z divider, the 31-stage reciprocal divider
// and the 42-stage exp series
// a two-entry output (tail register plus skid) keeps in_ready registered
// reset: synchronous active-low rst_n clears all valid bits, no item in flight
`timescale 1ns / 1ps
module normal_cdf_zscore_probability_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_drift,
  input  logic [30:0] in_volatility,
  input  logic [15:0] in_weeks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_z_value,
  output logic [31:0] out_probability,
  output logic [1:0]  out_status
);
  import ncdf_pkg::*;

  typedef struct packed {
    status_t     st;
    logic        neg;
    logic [31:0] mag;
    logic [30:0] vol;
  } hdr_t;

  typedef struct packed {
    status_t st;
    logic    neg;
  } zs_t;

  typedef struct packed {
    status_t     st;
    logic        neg;
    logic [31:0] zout;
    logic [4:0]  n;
    logic [31:0] f;
    logic        xbig;
  } cdf_t;

  typedef struct packed {
    cdf_t               c;
    logic [30:0]        t;
    logic signed [33:0] poly;
    logic [33:0]        rmag;
    logic               rneg;
  } pl_t;

  typedef struct packed {
    cdf_t               c;
    logic [32:0]        poly;
    logic [32:0]        term;
    logic signed [35:0] acc;
    logic [32:0]        w;
    logic [32:0]        q0;
  } ex_t;

  typedef struct packed {
    cdf_t        c;
    logic [32:0] poly;
    logic [32:0] u;
  } pw_t;

  localparam int POLY_STAGES = 10;
  localparam int TX_STAGES   = 3 * TAYLOR_TERMS;
  localparam logic [63:0] ZMAX = 64'((65'd1 << (DATA_WIDTH - 1)) - 65'd1);

  logic en;
  logic sk_v_r;

  // global advance: the pipe moves unless the skid entry is occupied
  assign en       = !sk_v_r;
  assign in_ready = en;

  // ------------------------------------------------------------------
  // input decode
  hdr_t in_hdr;
  always_comb begin
    in_hdr.neg = in_drift[31];
    in_hdr.mag = in_drift[31] ? 32'(-in_drift) : in_drift;
    in_hdr.vol = in_volatility;
    if (in_weeks == 16'd0) begin
      in_hdr.st = ST_WEEKS;
    end else if (in_volatility == 31'd0) begin
      in_hdr.st = ST_VOL;
    end else begin
      in_hdr.st = ST_OK;
    end
  end

  // ------------------------------------------------------------------
  // integer square root of weeks << 32, one result bit per stage
  hdr_t        sq_h_r    [SQRT_STEPS];
  logic [47:0] sq_rem_r  [SQRT_STEPS];
  logic [47:0] sq_root_r [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] sq_v_r;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [47:0] BIT = 48'd1 << (46 - 2 * i);
    hdr_t        h_in;
    logic [47:0] rem_in;
    logic [47:0] root_in;
    logic [47:0] trial;

    if (i == 0) begin : g_first
      assign h_in    = in_hdr;
      assign rem_in  = {in_weeks, 32'd0};
      assign root_in = '0;
    end else begin : g_next
      assign h_in    = sq_h_r[i-1];
      assign rem_in  = sq_rem_r[i-1];
      assign root_in = sq_root_r[i-1];
    end

    assign trial = root_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_h_r[i] <= h_in;
        if (rem_in >= trial) begin
          sq_rem_r[i]  <= rem_in - trial;
          sq_root_r[i] <= (root_in >> 1) + BIT;
        end else begin
          sq_rem_r[i]  <= rem_in;
          sq_root_r[i] <= root_in >> 1;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // dividend |mu| * sqrt(weeks) << 8
  logic        ml_v_r;
  zs_t         ml_side_r;
  logic [63:0] ml_num_r;
  logic [30:0] ml_vol_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ml_side_r.st  <= sq_h_r[SQRT_STEPS-1].st;
      ml_side_r.neg <= sq_h_r[SQRT_STEPS-1].neg;
      ml_num_r      <= {56'(sq_h_r[SQRT_STEPS-1].mag) *
                        56'(sq_root_r[SQRT_STEPS-1][23:0]), 8'd0};
      ml_vol_r      <= sq_h_r[SQRT_STEPS-1].vol;
    end
  end

  // z magnitude divider
  logic        zd_v;
  logic [63:0] zd_quo;
  logic [$bits(zs_t)-1:0] zd_side_raw;
  zs_t         zd_side;

  ncdf_div #(
    .DEN_W (31),
    .QUO_W (64),
    .SIDE_W($bits(zs_t))
  ) u_zdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (ml_v_r),
    .in_rem   (31'd0),
    .in_num   (ml_num_r),
    .in_den   (ml_vol_r),
    .in_side  (ml_side_r),
    .out_valid(zd_v),
    .out_quo  (zd_quo),
    .out_side (zd_side_raw)
  );
  assign zd_side = zd_side_raw;

  // ------------------------------------------------------------------
  // saturate z, apply sign, clamp cdf input
  logic [63:0]           zs_lim;
  logic [63:0]           zs_mag;
  logic [DATA_WIDTH-1:0] zs_sat;
  logic [63:0]           zs_ext;
  logic                  zs_neg;

  logic        sa_v_r;
  status_t     sa_st_r;
  logic        sa_neg_r;
  logic [31:0] sa_zout_r;
  logic [31:0] sa_zc_r;

  always_comb begin
    zs_lim = zd_side.neg ? ZMAX + 64'd1 : ZMAX;
    zs_mag = (zd_quo > zs_lim) ? zs_lim : zd_quo;
    zs_sat = DATA_WIDTH'(zs_mag);
    zs_ext = 64'(zs_sat);
    zs_neg = zd_side.neg && (zs_ext != 64'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_st_r   <= zd_side.st;
      sa_neg_r  <= zs_neg;
      sa_zout_r <= 32'(zs_neg ? -zs_ext : zs_ext);
      sa_zc_r   <= (zs_ext > 64'h8000_0000) ? 32'h8000_0000 : zs_ext[31:0];
    end
  end

  // x = |z| / sqrt2
  logic        xs_v_r;
  status_t     xs_st_r;
  logic        xs_neg_r;
  logic [31:0] xs_zout_r;
  logic [30:0] xs_x_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xs_st_r   <= sa_st_r;
      xs_neg_r  <= sa_neg_r;
      xs_zout_r <= sa_zout_r;
      xs_x_r    <= 31'((64'(sa_zc_r) * 64'(COEF_R) + 64'h8000_0000) >> 32);
    end
  end

  // d = 1 + p*x and u = x^2 split into whole and fraction
  logic [63:0] dd_pp;
  logic [63:0] dd_sq;
  logic [63:0] dd_u;
  cdf_t        dd_nxt;

  logic        dd_v_r;
  cdf_t        dd_c_r;
  logic [37:0] dd_d_r;

  always_comb begin
    dd_pp       = 64'(xs_x_r) * 64'(COEF_P);
    dd_sq       = 64'(xs_x_r) * 64'(xs_x_r);
    dd_u        = (dd_sq + 64'd32768) >> 16;
    dd_nxt.st   = xs_st_r;
    dd_nxt.neg  = xs_neg_r;
    dd_nxt.zout = xs_zout_r;
    dd_nxt.n    = dd_u[36:32];
    dd_nxt.f    = dd_u[31:0];
    dd_nxt.xbig = xs_x_r >= X_LIMIT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd_c_r <= dd_nxt;
      dd_d_r <= 38'(64'h1_0000_0000 + ((dd_pp + 64'd8388608) >> 24));
    end
  end

  // t = 2^62 / d, rounded
  logic [63:0] td_num;
  logic        td_v;
  logic [30:0] td_quo;
  logic [$bits(cdf_t)-1:0] td_side_raw;
  cdf_t        td_side;

  assign td_num = 64'h4000_0000_0000_0000 + 64'(dd_d_r >> 1);

  ncdf_div #(
    .DEN_W (38),
    .QUO_W (31),
    .SIDE_W($bits(cdf_t))
  ) u_tdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (dd_v_r),
    .in_rem   (38'(td_num >> 31)),
    .in_num   (td_num[30:0]),
    .in_den   (dd_d_r),
    .in_side  (dd_c_r),
    .out_valid(td_v),
    .out_quo  (td_quo),
    .out_side (td_side_raw)
  );
  assign td_side = td_side_raw;

  // ------------------------------------------------------------------
  // horner polynomial in t, a multiply stage and an add stage per term
  pl_t pl_r [POLY_STAGES];
  logic [POLY_STAGES-1:0] pl_v_r;

  for (genvar j = 0; j < 5; j++) begin : g_poly
    pl_t                src;
    pl_t                mul_nxt;
    pl_t                add_nxt;
    logic [32:0]        pmag;
    logic [63:0]        prod;
    logic signed [33:0] sval;

    if (j == 0) begin : g_first
      always_comb begin
        src      = '0;
        src.c    = td_side;
        src.t    = td_quo;
        src.poly = POLY_COEF[4];
      end
    end else begin : g_next
      assign src = pl_r[2*j-1];
    end

    // rounded magnitude product, sign kept aside
    always_comb begin
      pmag         = src.poly[33] ? 33'(-src.poly) : 33'(src.poly);
      prod         = 64'(pmag) * 64'(src.t);
      mul_nxt      = src;
      mul_nxt.rmag = 34'((prod + 64'd536870912) >> 30);
      mul_nxt.rneg = src.poly[33];
    end

    assign sval = pl_r[2*j].rneg ? -$signed(pl_r[2*j].rmag) : $signed(pl_r[2*j].rmag);

    if (j < 4) begin : g_add
      always_comb begin
        add_nxt      = pl_r[2*j];
        add_nxt.poly = sval + POLY_COEF[3-j];
      end
    end else begin : g_clamp
      always_comb begin
        add_nxt      = pl_r[2*j];
        add_nxt.poly = (sval < 0) ? 34'sd0 : sval;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pl_r[2*j]   <= mul_nxt;
        pl_r[2*j+1] <= add_nxt;
      end
    end
  end

  // ------------------------------------------------------------------
  // exp(-f) series, three stages per term: multiply, reciprocal, correct
  ex_t tx_r [TX_STAGES];
  logic [TX_STAGES-1:0] tx_v_r;

  for (genvar m = 0; m < TAYLOR_TERMS; m++) begin : g_tay
    localparam int K = m + 1;
    localparam logic [35:0] RECIP = 36'((64'd1 << RECIP_SHIFT) / K);
    localparam logic [32:0] KHALF = 33'(K / 2);
    ex_t         src;
    ex_t         a_nxt;
    ex_t         b_nxt;
    ex_t         c_nxt;
    logic [63:0] prod;
    logic [68:0] rprod;
    logic [32:0] rem;
    logic [32:0] quo;

    if (m == 0) begin : g_first
      always_comb begin
        src      = '0;
        src.c    = pl_r[POLY_STAGES-1].c;
        src.poly = 33'(pl_r[POLY_STAGES-1].poly);
        src.term = 33'h1_0000_0000;
        src.acc  = 36'sh1_0000_0000;
      end
    end else begin : g_next
      assign src = tx_r[3*m-1];
    end

    // term * f, rounded, plus k/2 for the divide
    always_comb begin
      prod    = 64'(src.term) * 64'(src.c.f);
      a_nxt   = src;
      a_nxt.w = 33'(((prod + 64'h8000_0000) >> 32) + 64'(KHALF));
    end

    // quotient estimate from the reciprocal, at most one low
    always_comb begin
      rprod    = 69'(tx_r[3*m].w) * 69'(RECIP);
      b_nxt    = tx_r[3*m];
      b_nxt.q0 = 33'(rprod >> RECIP_SHIFT);
    end

    // correct the estimate and accumulate with alternating sign
    always_comb begin
      rem        = tx_r[3*m+1].w - 33'(tx_r[3*m+1].q0 * 33'(K));
      quo        = (rem >= 33'(K)) ? tx_r[3*m+1].q0 + 33'd1 : tx_r[3*m+1].q0;
      c_nxt      = tx_r[3*m+1];
      c_nxt.term = quo;
      if (K % 2 == 1) begin
        c_nxt.acc = tx_r[3*m+1].acc - $signed({3'd0, quo});
      end else begin
        c_nxt.acc = tx_r[3*m+1].acc + $signed({3'd0, quo});
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tx_r[3*m]   <= a_nxt;
        tx_r[3*m+1] <= b_nxt;
        tx_r[3*m+2] <= c_nxt;
      end
    end
  end

  // clamp the series to [0, 1]
  ex_t  ec_src;
  pw_t  ec_nxt;
  logic ec_v_r;
  pw_t  ec_r;

  assign ec_src = tx_r[TX_STAGES-1];

  always_comb begin
    ec_nxt.c    = ec_src.c;
    ec_nxt.poly = ec_src.poly;
    if (ec_src.acc < 0) begin
      ec_nxt.u = '0;
    end else if (ec_src.acc > 36'sh1_0000_0000) begin
      ec_nxt.u = 33'h1_0000_0000;
    end else begin
      ec_nxt.u = 33'(ec_src.acc);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ec_r <= ec_nxt;
    end
  end

  // multiply by e^-1 once per whole unit of x^2
  pw_t pw_r [EXP_STEPS];
  logic [EXP_STEPS-1:0] pw_v_r;

  for (genvar i = 0; i < EXP_STEPS; i++) begin : g_pow
    pw_t src;
    pw_t nxt;

    if (i == 0) begin : g_first
      assign src = ec_r;
    end else begin : g_next
      assign src = pw_r[i-1];
    end

    always_comb begin
      nxt = src;
      if (5'(i) < src.c.n) begin
        nxt.u = 33'((64'(src.u) * 64'(COEF_E1) + 64'h8000_0000) >> 32);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pw_r[i] <= nxt;
      end
    end
  end

  // ------------------------------------------------------------------
  // q = poly * exp(-x^2)
  logic [32:0] qq_e;
  logic        qq_v_r;
  cdf_t        qq_c_r;
  logic [33:0] qq_q_r;

  assign qq_e = pw_r[EXP_STEPS-1].c.xbig ? 33'd0 : pw_r[EXP_STEPS-1].u;

  always_ff @(posedge clk) begin
    if (en) begin
      qq_c_r <= pw_r[EXP_STEPS-1].c;
      qq_q_r <= 34'((66'(pw_r[EXP_STEPS-1].poly) * 66'(qq_e) + 66'h8000_0000) >> 32);
    end
  end

  // erf to probability, error overrides
  logic [30:0] fn_y;
  logic [31:0] fn_y2;
  logic [32:0] fn_pos;
  logic [31:0] fn_pr;

  logic        tl_v_r;
  status_t     tl_st_r;
  logic [31:0] tl_z_r;
  logic [31:0] tl_p_r;

  always_comb begin
    fn_y   = (qq_q_r >= 34'h4000_0000) ? 31'd0 : 31'(34'h4000_0000 - qq_q_r);
    fn_y2  = {fn_y, 1'b0};
    fn_pos = 33'h8000_0000 + 33'(fn_y2);
    if (qq_c_r.neg) begin
      fn_pr = (fn_y2 >= 32'h8000_0000) ? 32'd0 : 32'h8000_0000 - fn_y2;
    end else begin
      fn_pr = (fn_pos > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : fn_pos[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tl_st_r <= qq_c_r.st;
      if (qq_c_r.st == ST_OK) begin
        tl_z_r <= qq_c_r.zout;
        tl_p_r <= fn_pr;
      end else begin
        tl_z_r <= '0;
        tl_p_r <= '0;
      end
    end
  end

  // ------------------------------------------------------------------
  // valid bits for every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= '0;
      ml_v_r <= 1'b0;
      sa_v_r <= 1'b0;
      xs_v_r <= 1'b0;
      dd_v_r <= 1'b0;
      pl_v_r <= '0;
      tx_v_r <= '0;
      ec_v_r <= 1'b0;
      pw_v_r <= '0;
      qq_v_r <= 1'b0;
      tl_v_r <= 1'b0;
    end else if (en) begin
      sq_v_r <= {sq_v_r[SQRT_STEPS-2:0], in_valid};
      ml_v_r <= sq_v_r[SQRT_STEPS-1];
      sa_v_r <= zd_v;
      xs_v_r <= sa_v_r;
      dd_v_r <= xs_v_r;
      pl_v_r <= {pl_v_r[POLY_STAGES-2:0], td_v};
      tx_v_r <= {tx_v_r[TX_STAGES-2:0], pl_v_r[POLY_STAGES-1]};
      ec_v_r <= tx_v_r[TX_STAGES-1];
      pw_v_r <= {pw_v_r[EXP_STEPS-2:0], ec_v_r};
      qq_v_r <= pw_v_r[EXP_STEPS-1];
      tl_v_r <= qq_v_r;
    end
  end

  // ------------------------------------------------------------------
  // skid entry holds the tail item when the pipe moves under a stall
  status_t     sk_st_r;
  logic [31:0] sk_z_r;
  logic [31:0] sk_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_v_r <= 1'b0;
    end else if (sk_v_r) begin
      if (out_ready) begin
        sk_v_r <= 1'b0;
      end
    end else if (tl_v_r && !out_ready) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_v_r) begin
      sk_st_r <= tl_st_r;
      sk_z_r  <= tl_z_r;
      sk_p_r  <= tl_p_r;
    end
  end

  assign out_valid       = sk_v_r || tl_v_r;
  assign out_z_value     = sk_v_r ? sk_z_r : tl_z_r;
  assign out_probability = sk_v_r ? sk_p_r : tl_p_r;
  assign out_status      = sk_v_r ? sk_st_r : tl_st_r;

endmodule

### rtl/ncdf_chk.sv
// port-level checker for the normal cdf z-score unit and its bind
`timescale 1ns / 1ps
module ncdf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_z_value,
  input logic [31:0] out_probability,
  input logic [1:0]  out_status
);
  import ncdf_pkg::*;

  // an error item carries zero z and zero probability
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_z_value == 32'd0) &&
      (out_probability == 32'd0))
    else $error("error item with nonzero payload");

  // input side only backs up while a result is pending
  a_ready_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with no result waiting");

  // input side backs up only after an output stall
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("in_ready dropped without an output stall");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_z_value) &&
      $stable(out_probability) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind normal_cdf_zscore_probability_unit ncdf_chk u_ncdf_chk (.*);
